// ===== hw/rtl/sfcc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfcc_pkg: shared types and constants for the SML frame checker
// Escape sequences, CRC-16/X-25 constants, mode codes and the result record.
// ----------------------------------------------------------------------------
package sfcc_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int CRC_W  = 16;
    localparam int FLEN_W = 11;

    // Collection modes
    localparam logic [1:0] MODE_SEARCH  = 2'd0;
    localparam logic [1:0] MODE_COLLECT = 2'd1;
    localparam logic [1:0] MODE_TAIL    = 2'd2;

    // Tail byte positions
    localparam logic [1:0] TAIL_PAD    = 2'd0;
    localparam logic [1:0] TAIL_CRC_LO = 2'd1;
    localparam logic [1:0] TAIL_CRC_HI = 2'd2;

    // Escape sequences, oldest byte in the top bits
    localparam logic [63:0] START_SEQ = 64'h1B1B_1B1B_0101_0101;
    localparam logic [39:0] END_SEQ   = 40'h1B_1B1B_1B1A;
    localparam int          START_LEN = 8;

    // CRC-16/X-25, reflected
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8408;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_XOR  = 16'hFFFF;

    // One byte through the reflected CRC, bit at a time
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // CRC state after the whole start escape
    function automatic logic [CRC_W-1:0] start_crc();
        logic [CRC_W-1:0] c;
        c = CRC_INIT;
        for (int k = 0; k < START_LEN; k++) begin
            c = crc_byte(c, START_SEQ[63 - 8*k -: 8]);
        end
        return c;
    endfunction

    localparam logic [CRC_W-1:0] CRC_START = start_crc();

    // One result record
    typedef struct packed {
        logic [BYTE_W-1:0] byte_echo;
        logic              in_frame;
        logic              start_found;
        logic              frame_done;
        logic              frame_good;
        logic              overflow;
        logic [CRC_W-1:0]  computed_crc;
        logic [CRC_W-1:0]  received_crc;
        logic [FLEN_W-1:0] frame_length;
    } t_result;

endpackage

// ===== hw/rtl/sfcc_res_buf.sv =====
// ----------------------------------------------------------------------------
// sfcc_res_buf: result register with skid stage
// Holds one result for the output and catches a second one while it stalls.
// ----------------------------------------------------------------------------
module sfcc_res_buf
    import sfcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_stall
);

    logic    r_valid;
    logic    r_skid_valid;
    t_result r_data;
    t_result r_skid;
    logic    take;
    logic    out_load;

    // output register free this cycle
    assign take     = r_valid && !i_stall;
    assign out_load = !r_valid || take;

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_load) begin
            if (r_skid_valid) begin
                r_valid      <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_valid <= i_load;
            end
        end else if (i_load) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_data <= r_skid_valid ? r_skid : i_data;
        end else if (i_load) begin
            r_skid <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/sml_frame_crc_checker_core.sv =====
// Throughput: one byte per cycle while o_rx_stall is low; the CRC byte update
// and window compares sit between the frame state and the result register.
// A skid stage behind the result register keeps input flowing for one
// stalled result. Reset (synchronous, active low) returns to searching,
// clears the window, preloads the CRC and clears ignore_crc.
// ----------------------------------------------------------------------------
// sml_frame_crc_checker_core: SML transport frame finder and CRC check
// Finds start/end escapes, reads the tail and checks CRC-16/X-25 per frame.
// ----------------------------------------------------------------------------
module sml_frame_crc_checker_core
    import sfcc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 1024
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte request channel
    input  logic              i_rx_valid,
    output logic              o_rx_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    // configuration
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    // result request channel
    output logic              o_res_valid,
    input  logic              i_res_stall,
    output logic [BYTE_W-1:0] o_byte_echo,
    output logic              o_in_frame,
    output logic              o_start_found,
    output logic              o_frame_done,
    output logic              o_frame_good,
    output logic              o_overflow,
    output logic [CRC_W-1:0]  o_computed_crc,
    output logic [CRC_W-1:0]  o_received_crc,
    output logic [FLEN_W-1:0] o_frame_length
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

    // frame state
    logic [63:0]       r_win,        n_win;
    logic [1:0]        r_mode,       n_mode;
    logic [CRC_W-1:0]  r_crc,        n_crc;
    logic [1:0]        r_tail_cnt,   n_tail_cnt;
    logic [BYTE_W-1:0] r_crc_lo,     n_crc_lo;
    logic [CNT_W-1:0]  r_byte_cnt,   n_byte_cnt;
    logic              r_ignore_crc;

    logic              accept;
    logic              buf_full;
    logic [63:0]       win_shift;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CRC_W-1:0]  crc_upd;
    logic [CRC_W-1:0]  rx_crc;
    logic [CRC_W-1:0]  fin_crc;
    t_result           res;
    t_result           out_res;

    assign accept    = i_rx_valid && !buf_full;
    assign win_shift = {r_win[55:0], i_rx_byte};
    assign cnt_inc   = r_byte_cnt + 1'b1;
    assign crc_upd   = crc_byte(r_crc, i_rx_byte);
    assign rx_crc    = {i_rx_byte, r_crc_lo};
    assign fin_crc   = r_crc ^ CRC_XOR;

    // next state and result for the byte at the input
    always_comb begin
        n_win      = r_win;
        n_mode     = r_mode;
        n_crc      = r_crc;
        n_tail_cnt = r_tail_cnt;
        n_crc_lo   = r_crc_lo;
        n_byte_cnt = r_byte_cnt;

        res              = '0;
        res.byte_echo    = i_rx_byte;

        case (r_mode)
            MODE_COLLECT, MODE_TAIL: begin
                if (r_byte_cnt >= CNT_W'(MAX_FRAME_BYTES)) begin
                    // too long: abort and drop back to searching
                    res.overflow     = 1'b1;
                    res.frame_length = FLEN_W'(MAX_FRAME_BYTES);
                    n_win      = '0;
                    n_mode     = MODE_SEARCH;
                    n_crc      = CRC_INIT;
                    n_tail_cnt = '0;
                    n_crc_lo   = '0;
                    n_byte_cnt = '0;
                end else begin
                    res.in_frame     = 1'b1;
                    res.frame_length = FLEN_W'(cnt_inc);
                    n_byte_cnt       = cnt_inc;
                    if (r_mode == MODE_COLLECT) begin
                        n_win = win_shift;
                        n_crc = crc_upd;
                        if (win_shift[39:0] == END_SEQ) begin
                            n_mode     = MODE_TAIL;
                            n_tail_cnt = TAIL_PAD;
                        end
                    end else if (r_tail_cnt == TAIL_PAD) begin
                        n_crc      = crc_upd;
                        n_tail_cnt = TAIL_CRC_LO;
                    end else if (r_tail_cnt == TAIL_CRC_LO) begin
                        n_crc_lo   = i_rx_byte;
                        n_tail_cnt = TAIL_CRC_HI;
                    end else begin
                        // last tail byte: report and clear
                        res.frame_done   = 1'b1;
                        res.received_crc = rx_crc;
                        res.computed_crc = fin_crc;
                        res.frame_good   = r_ignore_crc || (fin_crc == rx_crc);
                        n_win      = '0;
                        n_mode     = MODE_SEARCH;
                        n_crc      = CRC_INIT;
                        n_tail_cnt = '0;
                        n_crc_lo   = '0;
                        n_byte_cnt = '0;
                    end
                end
            end
            default: begin
                // searching, unused code included
                n_win  = win_shift;
                n_mode = MODE_SEARCH;
                if (win_shift == START_SEQ) begin
                    res.start_found  = 1'b1;
                    res.in_frame     = 1'b1;
                    res.frame_length = FLEN_W'(START_LEN);
                    n_mode     = MODE_COLLECT;
                    n_crc      = CRC_START;
                    n_tail_cnt = '0;
                    n_byte_cnt = CNT_W'(START_LEN);
                end
            end
        endcase
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_mode     <= MODE_SEARCH;
            r_crc      <= CRC_INIT;
            r_tail_cnt <= '0;
            r_crc_lo   <= '0;
            r_byte_cnt <= '0;
        end else if (accept) begin
            r_win      <= n_win;
            r_mode     <= n_mode;
            r_crc      <= n_crc;
            r_tail_cnt <= n_tail_cnt;
            r_crc_lo   <= n_crc_lo;
            r_byte_cnt <= n_byte_cnt;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignore_crc <= 1'b0;
        end else if (i_cfg_we) begin
            r_ignore_crc <= i_cfg_wdata;
        end
    end

    // result register and skid stage
    sfcc_res_buf u_res_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_data  (res),
        .o_full  (buf_full),
        .o_valid (o_res_valid),
        .o_data  (out_res),
        .i_stall (i_res_stall)
    );

    assign o_rx_stall     = buf_full;
    assign o_byte_echo    = out_res.byte_echo;
    assign o_in_frame     = out_res.in_frame;
    assign o_start_found  = out_res.start_found;
    assign o_frame_done   = out_res.frame_done;
    assign o_frame_good   = out_res.frame_good;
    assign o_overflow     = out_res.overflow;
    assign o_computed_crc = out_res.computed_crc;
    assign o_received_crc = out_res.received_crc;
    assign o_frame_length = out_res.frame_length;

    // checks
    a_done_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_frame_done || o_start_found) |-> o_in_frame)
        else $error("frame_done or start_found outside a frame");

    a_ovf_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_overflow |-> !o_in_frame && !o_frame_done)
        else $error("overflow together with frame flags");

    a_cnt_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_COLLECT || r_mode == MODE_TAIL) |->
            (r_byte_cnt >= CNT_W'(START_LEN)))
        else $error("frame byte count below start escape length");

    a_stall_has_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> o_res_valid)
        else $error("input stalled with no result pending");

endmodule
